FILE: rtl/demand_paged_table_walker_top_assert.svh
// Assertion macros for the table walker.
`ifndef DEMAND_PAGED_TABLE_WALKER_TOP_ASSERT_SVH
`define DEMAND_PAGED_TABLE_WALKER_TOP_ASSERT_SVH

`ifndef SYNTH
`define DPTW_ASSERT_IMP(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) else $error(msg);
`define DPTW_ASSERT_NXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);
`else
`define DPTW_ASSERT_IMP(lbl, cond, conseq, msg)
`define DPTW_ASSERT_NXT(lbl, cond, conseq, msg)
`endif

`endif

FILE: rtl/dptw_pkg.sv
// Shared types and constants of the table walker.
package dptw_pkg;

  localparam int VF_W    = 36;
  localparam int VF_TW   = 40;
  localparam int FRAME_W = 52;
  localparam int OUT_TW  = 56;
  localparam int LIMIT_W = 9;
  localparam int CFG_DW  = 64;
  localparam int CFG_AW  = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  // Register select is address bit 3 (registers at byte 0 and 8)
  localparam logic REG_BASE_FRAME = 1'b0;
  localparam logic REG_POOL_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_OUT
  } dptw_state_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } dptw_mem_cmd_t;

endpackage

FILE: rtl/demand_paged_table_walker_top.sv
// Top level of the demand-paged radix table walker.
//
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    virtual_frame
//  m_*       out  m_tvalid / m_tready    host_frame; tuser newly_mapped, fault
//  APB       in   psel&penable&pwrite    base_frame @0x0, pool_limit @0x8
//
// A walk goes from idle through a read and a check/allocate per level on the
// single-port store (registered read data), then to the hand-off state and back to
// idle; a walk that faults stops at the failing level.
// After reset a clearing pass zeroes all POOL_PAGES*2^INDEX_BITS entries of the
// store (131072 by default), one entry a cycle; s_tready stays low.
// A result waits in the output register while the next item walks; that walk holds
// in hand-off until the register frees.
`include "demand_paged_table_walker_top_assert.svh"

module demand_paged_table_walker_top #(
  parameter int POOL_PAGES = 256,
  parameter int LEVELS     = 4,
  parameter int INDEX_BITS = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [dptw_pkg::VF_TW-1:0]  s_tdata,  // [35:0] virtual_frame
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [dptw_pkg::OUT_TW-1:0] m_tdata,  // [51:0] host_frame
  output logic [1:0]                  m_tuser,  // [0] newly_mapped, [1] fault
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dptw_pkg::CFG_AW-1:0] paddr,
  input  logic [dptw_pkg::CFG_DW-1:0] pwdata,
  output logic [dptw_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import dptw_pkg::*;

  localparam int PAGE_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int ADDR_W = PAGE_W + INDEX_BITS;
  localparam int DEPTH  = POOL_PAGES * (2 ** INDEX_BITS);
  localparam int TOT_W  = LEVELS * INDEX_BITS;
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CMP_W  = (PAGE_W + 1 > LIMIT_W) ? PAGE_W + 1 : LIMIT_W;

  dptw_state_t state, state_next;

  logic [FRAME_W-1:0] base_frame;
  logic [LIMIT_W-1:0] pool_limit;
  logic [PAGE_W:0]    next_free;
  logic [ADDR_W-1:0]  clr_addr;
  logic [TOT_W-1:0]   vf_sh;
  logic [PAGE_W-1:0]  table_pg;
  logic [LVL_W-1:0]   lvl;
  logic [FRAME_W-1:0] host_frame;
  logic               newly_mapped;
  logic               fault;
  logic               out_valid;
  logic [FRAME_W-1:0] out_frame;
  logic               out_mapped;
  logic               out_fault;

  dptw_mem_cmd_t      mem_cmd;
  logic [ADDR_W-1:0]  mem_addr;
  logic [PAGE_W-1:0]  mem_wdata;
  logic [PAGE_W-1:0]  mem_rdata;

  logic [TOT_W+VF_W-1:0] vf_ext;
  logic [ADDR_W-1:0]  walk_addr;
  logic [CMP_W-1:0]   lim_cmp;
  logic               can_alloc;
  logic               entry_empty;
  logic               last_lvl;
  logic [PAGE_W-1:0]  child_pg;
  logic               cfg_wr;
  logic               out_free;

  dptw_store #(
    .ADDR_W (ADDR_W),
    .DATA_W (PAGE_W),
    .DEPTH  (DEPTH)
  ) u_store (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Allocation check: next free page below min(pool_limit, POOL_PAGES)
  always_comb begin
    vf_ext      = {{TOT_W{1'b0}}, s_tdata[VF_W-1:0]};
    walk_addr   = {table_pg, vf_sh[TOT_W-1 -: INDEX_BITS]};
    lim_cmp     = (CMP_W'(pool_limit) > CMP_W'(POOL_PAGES)) ? CMP_W'(POOL_PAGES)
                                                            : CMP_W'(pool_limit);
    can_alloc   = CMP_W'(next_free) < lim_cmp;
    entry_empty = (mem_rdata == '0);
    last_lvl    = (lvl == LVL_W'(LEVELS - 1));
    child_pg    = entry_empty ? next_free[PAGE_W-1:0] : mem_rdata;
    cfg_wr      = psel & penable & pwrite & pready;
    out_free    = !out_valid || m_tready;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (s_tvalid) state_next = ST_RD;
      ST_RD:    state_next = ST_CHK;
      ST_CHK: begin
        if ((entry_empty && !can_alloc) || last_lvl) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    mem_cmd   = '0;
    mem_addr  = walk_addr;
    mem_wdata = next_free[PAGE_W-1:0];
    s_tready  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_cmd.wr = 1'b1;
        mem_addr   = clr_addr;
        mem_wdata  = '0;
      end
      ST_IDLE:  s_tready = 1'b1;
      ST_RD:    mem_cmd.rd = 1'b1;
      ST_CHK:   mem_cmd.wr = entry_empty & can_alloc;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      next_free <= (PAGE_W + 1)'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ST_CHK && entry_empty && can_alloc) begin
        next_free <= next_free + 1'b1;
      end
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_frame <= '0;
      pool_limit <= LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_BASE_FRAME: base_frame <= pwdata[FRAME_W-1:0];
        REG_POOL_LIMIT: pool_limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Walk datapath: hold the index bits top-aligned and shift one level a step
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      vf_sh    <= vf_ext[TOT_W-1:0];
      table_pg <= '0;
      lvl      <= '0;
    end
    if (state == ST_CHK) begin
      if (entry_empty && !can_alloc) begin
        host_frame   <= '0;
        newly_mapped <= 1'b0;
        fault        <= 1'b1;
      end else if (last_lvl) begin
        host_frame   <= base_frame + FRAME_W'(child_pg);
        newly_mapped <= entry_empty;
        fault        <= 1'b0;
      end else begin
        table_pg <= child_pg;
        lvl      <= lvl + 1'b1;
        vf_sh    <= vf_sh << INDEX_BITS;
      end
    end
    // hand the finished walk to the output register once it frees
    if (state == ST_OUT && out_free) begin
      out_frame  <= host_frame;
      out_mapped <= newly_mapped;
      out_fault  <= fault;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_TW - FRAME_W){1'b0}}, out_frame};
  assign m_tuser  = {out_fault, out_mapped};
  assign pready   = 1'b1;
  assign prdata   = (paddr[3] == REG_POOL_LIMIT) ? CFG_DW'(pool_limit) : CFG_DW'(base_frame);

  `DPTW_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `DPTW_ASSERT_IMP(a_free_bound, 1'b1, next_free <= (PAGE_W + 1)'(POOL_PAGES), "allocator past pool")
  `DPTW_ASSERT_IMP(a_fault_zero, m_tvalid && m_tuser[1], m_tdata == '0 && !m_tuser[0], "bad fault result")
  `DPTW_ASSERT_NXT(a_accept_walk, s_tvalid && s_tready, state == ST_RD, "walk did not start")
  `DPTW_ASSERT_IMP(a_bump_step, !$past(rst), next_free == $past(next_free) || next_free == $past(next_free) + 1'b1, "allocator jumped")

endmodule

FILE: rtl/dptw_store.sv
// Single-port table store with registered read data.
module dptw_store #(
  parameter int ADDR_W = 17,
  parameter int DATA_W = 8,
  parameter int DEPTH  = 131072
) (
  input  logic                  clk,
  input  dptw_pkg::dptw_mem_cmd_t cmd,
  input  logic [ADDR_W-1:0]     addr,
  input  logic [DATA_W-1:0]     wdata,
  output logic [DATA_W-1:0]     rdata
);
  import dptw_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule
